// ===== rtl/mspd_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor speed PID package
// Shared widths, register indexes, reset values and the configuration type.
// ----------------------------------------------------------------------------
`default_nettype none

package mspd_pkg;

    localparam int GAIN_W  = 10;
    localparam int DUTY_W  = 16;
    localparam int CMD_W   = 8;
    localparam int MEAS_W  = 16;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;

    localparam logic [CIDX_W-1:0] CFG_GAIN_P   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_GAIN_I   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_GAIN_D   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_DUTY = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_SWAP_DIR = 3'd4;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_CONTROL = 1'b1;

    localparam logic [GAIN_W-1:0] RST_GAIN_P   = 10'd50;
    localparam logic [GAIN_W-1:0] RST_GAIN_I   = 10'd10;
    localparam logic [GAIN_W-1:0] RST_GAIN_D   = 10'd2;
    localparam logic [DUTY_W-1:0] RST_MAX_DUTY = 16'd3600;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [DUTY_W-1:0] max_duty;
        logic              swap_direction;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/mspd_core.sv =====
// ----------------------------------------------------------------------------
// Motor speed PID core
// Holds the controller state and works out the pins and duty of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module mspd_core #(
    parameter int INTEGRAL_BITS = 24
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_update,
    input  wire                                     i_action,
    input  wire  signed [mspd_pkg::CMD_W-1:0]       i_command_speed,
    input  wire  signed [mspd_pkg::MEAS_W-1:0]      i_measured_speed,
    input  wire  mspd_pkg::t_cfg                    i_cfg,
    output logic                                    o_pin_a,
    output logic                                    o_pin_b,
    output logic        [mspd_pkg::DUTY_W-1:0]      o_duty
);

    localparam int IW = ((INTEGRAL_BITS > mspd_pkg::ERR_W) ?
                         INTEGRAL_BITS : mspd_pkg::ERR_W) + 1;
    localparam int PW = ((INTEGRAL_BITS > mspd_pkg::DIFF_W) ?
                         INTEGRAL_BITS : mspd_pkg::DIFF_W) + mspd_pkg::GAIN_W + 3;
    localparam logic signed [IW-1:0] I_MAX =
        {{(IW-INTEGRAL_BITS+1){1'b0}}, {(INTEGRAL_BITS-1){1'b1}}};
    localparam logic signed [IW-1:0] I_MIN =
        {{(IW-INTEGRAL_BITS+1){1'b1}}, {(INTEGRAL_BITS-1){1'b0}}};

    logic                                r_pending;
    logic signed [INTEGRAL_BITS-1:0]     r_integral;
    logic signed [mspd_pkg::ERR_W-1:0]   r_prev_err;
    logic        [mspd_pkg::DUTY_W-1:0]  r_duty_hold;
    logic        [1:0]                   r_pin_hold;

    logic                                n_pending;
    logic signed [INTEGRAL_BITS-1:0]     n_integral;
    logic signed [mspd_pkg::ERR_W-1:0]   n_prev_err;
    logic        [mspd_pkg::DUTY_W-1:0]  n_duty_hold;
    logic        [1:0]                   n_pin_hold;

    logic                                cmd_neg;
    logic                                cmd_zero;
    logic        [mspd_pkg::CMD_W-1:0]   wanted;
    logic signed [mspd_pkg::ERR_W-1:0]   err;
    logic signed [mspd_pkg::DIFF_W-1:0]  diff;
    logic signed [IW-1:0]                isum;
    logic signed [INTEGRAL_BITS-1:0]     isat;
    logic signed [PW-1:0]                term_p;
    logic signed [PW-1:0]                term_i;
    logic signed [PW-1:0]                term_d;
    logic signed [PW-1:0]                pid_sum;
    logic signed [PW-1:0]                max_ext;
    logic        [mspd_pkg::DUTY_W-1:0]  pid_duty;
    logic                                pin_a_raw;
    logic                                pin_b_raw;

    always_comb begin
        cmd_neg  = i_command_speed[mspd_pkg::CMD_W-1];
        cmd_zero = (i_command_speed == '0);
        wanted   = cmd_neg ? (~i_command_speed + mspd_pkg::CMD_W'(1)) : i_command_speed;
        err      = $signed({{(mspd_pkg::ERR_W-mspd_pkg::CMD_W){1'b0}}, wanted})
                 - mspd_pkg::ERR_W'(i_measured_speed);
        diff     = mspd_pkg::DIFF_W'(err) - mspd_pkg::DIFF_W'(r_prev_err);

        isum = IW'(r_integral) + IW'(err);
        if (isum > I_MAX) begin
            isat = I_MAX[INTEGRAL_BITS-1:0];
        end else if (isum < I_MIN) begin
            isat = I_MIN[INTEGRAL_BITS-1:0];
        end else begin
            isat = isum[INTEGRAL_BITS-1:0];
        end

        term_p  = PW'($signed({1'b0, i_cfg.gain_p}) * err);
        term_i  = PW'($signed({1'b0, i_cfg.gain_i}) * isat);
        term_d  = PW'($signed({1'b0, i_cfg.gain_d}) * diff);
        pid_sum = term_p + term_i + term_d;
        max_ext = $signed(PW'(i_cfg.max_duty));

        if (pid_sum[PW-1]) begin
            pid_duty = '0;
        end else if (pid_sum > max_ext) begin
            pid_duty = i_cfg.max_duty;
        end else begin
            pid_duty = pid_sum[mspd_pkg::DUTY_W-1:0];
        end

        pin_a_raw = cmd_neg || cmd_zero;
        pin_b_raw = !cmd_neg;

        n_pending   = r_pending;
        n_integral  = r_integral;
        n_prev_err  = r_prev_err;
        n_duty_hold = r_duty_hold;
        n_pin_hold  = r_pin_hold;

        if (i_action == mspd_pkg::ACT_TICK) begin
            n_pending = 1'b1;
        end else begin
            n_pin_hold = i_cfg.swap_direction ? {pin_b_raw, pin_a_raw}
                                              : {pin_a_raw, pin_b_raw};
            if (cmd_zero) begin
                n_integral  = '0;
                n_prev_err  = '0;
                n_duty_hold = '0;
            end else if (r_pending) begin
                n_integral  = isat;
                n_prev_err  = err;
                n_duty_hold = pid_duty;
                n_pending   = 1'b0;
            end
        end

        o_pin_a = n_pin_hold[1];
        o_pin_b = n_pin_hold[0];
        o_duty  = (n_duty_hold < i_cfg.max_duty) ? n_duty_hold : i_cfg.max_duty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_integral  <= '0;
            r_prev_err  <= '0;
            r_duty_hold <= '0;
            r_pin_hold  <= '0;
        end else if (i_update) begin
            r_pending   <= n_pending;
            r_integral  <= n_integral;
            r_prev_err  <= n_prev_err;
            r_duty_hold <= n_duty_hold;
            r_pin_hold  <= n_pin_hold;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/motor_speed_pid_with_direction.sv =====
// ----------------------------------------------------------------------------
// Motor speed PID with direction
// Stage 1 registers the item, then a single registered PID pass fills the outputs.
// One item is accepted every cycle unless a stalled output holds stage 1.
// Synchronous active-low reset clears the PID state and the held pins and duty,
// not the output registers, and restores the gains, duty limit and direction.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_pid_with_direction #(
    parameter int INTEGRAL_BITS = 24
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  wire                                    i_action,
    input  wire  signed [mspd_pkg::CMD_W-1:0]      i_command_speed,
    input  wire  signed [mspd_pkg::MEAS_W-1:0]     i_measured_speed,
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output logic                                   o_pin_a,
    output logic                                   o_pin_b,
    output logic        [mspd_pkg::DUTY_W-1:0]     o_duty,
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire         [mspd_pkg::CIDX_W-1:0]     i_cfg_index,
    input  wire         [mspd_pkg::CDATA_W-1:0]    i_cfg_data
);

    mspd_pkg::t_cfg                        r_cfg;
    logic                                  r_s1_valid;
    logic                                  r_s1_action;
    logic signed [mspd_pkg::CMD_W-1:0]     r_s1_cmd;
    logic signed [mspd_pkg::MEAS_W-1:0]    r_s1_meas;
    logic                                  r_out_valid;
    logic                                  r_pin_a;
    logic                                  r_pin_b;
    logic        [mspd_pkg::DUTY_W-1:0]    r_duty;

    logic                                  advance;
    logic                                  update;
    logic                                  n_pin_a;
    logic                                  n_pin_b;
    logic        [mspd_pkg::DUTY_W-1:0]    n_duty;

    assign advance     = !r_out_valid || !i_out_stall;
    assign update      = r_s1_valid && advance;
    assign o_in_stall  = r_s1_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_pin_a     = r_pin_a;
    assign o_pin_b     = r_pin_b;
    assign o_duty      = r_duty;

    mspd_core #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_update         (update),
        .i_action         (r_s1_action),
        .i_command_speed  (r_s1_cmd),
        .i_measured_speed (r_s1_meas),
        .i_cfg            (r_cfg),
        .o_pin_a          (n_pin_a),
        .o_pin_b          (n_pin_b),
        .o_duty           (n_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= mspd_pkg::RST_GAIN_P;
            r_cfg.gain_i         <= mspd_pkg::RST_GAIN_I;
            r_cfg.gain_d         <= mspd_pkg::RST_GAIN_D;
            r_cfg.max_duty       <= mspd_pkg::RST_MAX_DUTY;
            r_cfg.swap_direction <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mspd_pkg::CFG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_data[mspd_pkg::GAIN_W-1:0];
                end
                mspd_pkg::CFG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_data[mspd_pkg::GAIN_W-1:0];
                end
                mspd_pkg::CFG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_data[mspd_pkg::GAIN_W-1:0];
                end
                mspd_pkg::CFG_MAX_DUTY: begin
                    r_cfg.max_duty <= i_cfg_data[mspd_pkg::DUTY_W-1:0];
                end
                mspd_pkg::CFG_SWAP_DIR: begin
                    r_cfg.swap_direction <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_action <= i_action;
            r_s1_cmd    <= i_command_speed;
            r_s1_meas   <= i_measured_speed;
        end
        if (update) begin
            r_pin_a <= n_pin_a;
            r_pin_b <= n_pin_b;
            r_duty  <= n_duty;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Motor speed PID with direction: self-checking testbench
// Items are sent through a queue-fed driver while the result side stalls at
// random. Each accepted item is run through an in-bench controller that keeps
// its own gains, integral and bridge pins, and each result must match the
// oldest prediction. Register writes happen only between phases, once the
// block is idle, and cover zero, full-scale and random settings, including
// a run that drives the integral to its upper saturation limit.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     INTEG_BITS = 24;
    localparam longint INTEG_MAX  = (longint'(1) << (INTEG_BITS - 1)) - 1;
    localparam int     IDLE_LIMIT = 40000;

    typedef struct {
        logic                               action;
        logic signed [mspd_pkg::CMD_W-1:0]  cmd;
        logic signed [mspd_pkg::MEAS_W-1:0] meas;
    } t_ctl_item;

    typedef struct {
        logic                        pin_a;
        logic                        pin_b;
        logic [mspd_pkg::DUTY_W-1:0] duty;
    } t_bridge_out;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic                               i_action = mspd_pkg::ACT_TICK;
    logic signed [mspd_pkg::CMD_W-1:0]  i_command_speed = '0;
    logic signed [mspd_pkg::MEAS_W-1:0] i_measured_speed = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic                               o_pin_a;
    logic                               o_pin_b;
    logic [mspd_pkg::DUTY_W-1:0]        o_duty;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [mspd_pkg::CIDX_W-1:0]        i_cfg_index = mspd_pkg::CFG_GAIN_P;
    logic [mspd_pkg::CDATA_W-1:0]       i_cfg_data = '0;

    motor_speed_pid_with_direction #(
        .INTEGRAL_BITS(INTEG_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_command_speed (i_command_speed),
        .i_measured_speed(i_measured_speed),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pin_a         (o_pin_a),
        .o_pin_b         (o_pin_b),
        .o_duty          (o_duty),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Controller state as the block should hold it.
    mspd_pkg::t_cfg ctl_cfg = {mspd_pkg::RST_GAIN_P, mspd_pkg::RST_GAIN_I,
                               mspd_pkg::RST_GAIN_D, mspd_pkg::RST_MAX_DUTY, 1'b0};
    logic        tick_armed = 1'b0;
    longint      integ_acc = 0;
    longint      last_err = 0;
    longint      duty_held = 0;
    logic [1:0]  pins_held = 2'b00;

    t_ctl_item   cmd_backlog[$];
    t_bridge_out bridge_duty_q[$];
    t_ctl_item   cur_item;

    int  in_gap = 0;
    int  out_wait = 0;
    bit  in_calm = 1'b0;
    bit  out_calm = 1'b1;
    int  items_queued = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  reg_writes = 0;
    int  settings_used = 1;
    int  mismatches = 0;

    function automatic t_bridge_out step_controller(input t_ctl_item it);
        t_bridge_out r;
        int          w;
        longint      e;
        longint      d;
        longint      sum;
        logic        a;
        logic        b;
        if (it.action == mspd_pkg::ACT_TICK) begin
            tick_armed = 1'b1;
        end else begin
            w = int'(it.cmd);
            a = (w <= 0);
            b = (w >= 0);
            if (w < 0) begin
                w = -w;
            end
            pins_held = ctl_cfg.swap_direction ? {b, a} : {a, b};
            if (w == 0) begin
                integ_acc = 0;
                last_err  = 0;
                duty_held = 0;
            end else if (tick_armed) begin
                e = longint'(w) - longint'(it.meas);
                integ_acc = integ_acc + e;
                if (integ_acc > INTEG_MAX) begin
                    integ_acc = INTEG_MAX;
                end
                if (integ_acc < -INTEG_MAX - 1) begin
                    integ_acc = -INTEG_MAX - 1;
                end
                d = e - last_err;
                sum = longint'(ctl_cfg.gain_p) * e + longint'(ctl_cfg.gain_i) * integ_acc
                    + longint'(ctl_cfg.gain_d) * d;
                if (sum < 0) begin
                    sum = 0;
                end
                if (sum > longint'(ctl_cfg.max_duty)) begin
                    sum = longint'(ctl_cfg.max_duty);
                end
                duty_held  = sum;
                last_err   = e;
                tick_armed = 1'b0;
            end
        end
        r.pin_a = pins_held[1];
        r.pin_b = pins_held[0];
        r.duty  = (duty_held < longint'(ctl_cfg.max_duty)) ? mspd_pkg::DUTY_W'(duty_held)
                                                            : ctl_cfg.max_duty;
        return r;
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                bridge_duty_q.push_back(step_controller(cur_item));
                items_sent++;
            end
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                cur_item = cmd_backlog.pop_front();
                i_action         <= cur_item.action;
                i_command_speed  <= cur_item.cmd;
                i_measured_speed <= cur_item.meas;
                i_in_valid       <= 1'b1;
                in_gap           <= draw_wait(in_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_bridge_out want;
        int          nxt;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            nxt = out_wait;
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (bridge_duty_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("t=%0t result with no item waiting: a=%b b=%b duty=%0d",
                                 $realtime, o_pin_a, o_pin_b, o_duty);
                    end
                end else begin
                    want = bridge_duty_q.pop_front();
                    if (o_pin_a !== want.pin_a || o_pin_b !== want.pin_b
                        || o_duty !== want.duty) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"t=%0t result %0d: expected a=%b b=%b duty=%0d,",
                                      " got a=%b b=%b duty=%0d"},
                                     $realtime, results_seen, want.pin_a, want.pin_b,
                                     want.duty, o_pin_a, o_pin_b, o_duty);
                        end
                    end
                end
                nxt = draw_wait(out_calm);
            end
            if (nxt > 0) begin
                out_wait    <= nxt - 1;
                i_out_stall <= 1'b1;
            end else begin
                out_wait    <= 0;
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_item(input logic act, input int cmd, input int meas);
        t_ctl_item it;
        it.action = act;
        it.cmd    = mspd_pkg::CMD_W'(cmd);
        it.meas   = mspd_pkg::MEAS_W'(meas);
        cmd_backlog.push_back(it);
        items_queued++;
    endtask

    function automatic int rnd_cmd();
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    function automatic int rnd_meas();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic write_reg(input logic [mspd_pkg::CIDX_W-1:0] idx,
                             input int unsigned val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= mspd_pkg::CDATA_W'(val);
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            mspd_pkg::CFG_GAIN_P:   ctl_cfg.gain_p = mspd_pkg::GAIN_W'(val);
            mspd_pkg::CFG_GAIN_I:   ctl_cfg.gain_i = mspd_pkg::GAIN_W'(val);
            mspd_pkg::CFG_GAIN_D:   ctl_cfg.gain_d = mspd_pkg::GAIN_W'(val);
            mspd_pkg::CFG_MAX_DUTY: ctl_cfg.max_duty = mspd_pkg::DUTY_W'(val);
            mspd_pkg::CFG_SWAP_DIR: ctl_cfg.swap_direction = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_all(input int unsigned gp, input int unsigned gi,
                             input int unsigned gd, input int unsigned md,
                             input int unsigned sw);
        write_reg(mspd_pkg::CFG_GAIN_P, gp);
        write_reg(mspd_pkg::CFG_GAIN_I, gi);
        write_reg(mspd_pkg::CFG_GAIN_D, gd);
        write_reg(mspd_pkg::CFG_MAX_DUTY, md);
        write_reg(mspd_pkg::CFG_SWAP_DIR, sw);
        settings_used++;
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        while ((cmd_backlog.size() != 0 || i_in_valid || bridge_duty_q.size() != 0
                || results_seen < items_queued) && n < IDLE_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_mixed(input int n);
        int r;
        int c;
        int w;
        repeat (n) begin
            r = $urandom_range(0, 99);
            c = rnd_cmd();
            w = (c < 0) ? -c : c;
            if (r < 10) begin
                push_item(mspd_pkg::ACT_TICK, rnd_cmd(), rnd_meas());
            end else if (r < 70) begin
                push_item(mspd_pkg::ACT_TICK, rnd_cmd(), rnd_meas());
                push_item(mspd_pkg::ACT_CONTROL, c, w + int'($urandom_range(0, 200)) - 100);
            end else if (r < 82) begin
                push_item(mspd_pkg::ACT_TICK, rnd_cmd(), rnd_meas());
                push_item(mspd_pkg::ACT_CONTROL, c, rnd_meas());
            end else if (r < 92) begin
                push_item(mspd_pkg::ACT_CONTROL, c, rnd_meas());
            end else begin
                push_item(mspd_pkg::ACT_CONTROL, 0, rnd_meas());
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_item(mspd_pkg::ACT_TICK, -128, -32768);
        push_item(mspd_pkg::ACT_TICK, 127, 32767);
        push_item(mspd_pkg::ACT_CONTROL, 5, 3);
        push_item(mspd_pkg::ACT_CONTROL, -7, 100);
        push_item(mspd_pkg::ACT_TICK, 0, 0);
        push_item(mspd_pkg::ACT_CONTROL, 127, -32768);
        push_item(mspd_pkg::ACT_TICK, 1, -1);
        push_item(mspd_pkg::ACT_CONTROL, -128, 32767);
        push_item(mspd_pkg::ACT_TICK, -1, 1);
        push_item(mspd_pkg::ACT_CONTROL, 0, 0);
        push_item(mspd_pkg::ACT_CONTROL, 1, 0);
        push_item(mspd_pkg::ACT_TICK, 85, -21846);
        push_item(mspd_pkg::ACT_CONTROL, -1, 1);
        push_item(mspd_pkg::ACT_TICK, -86, 21845);
        push_item(mspd_pkg::ACT_CONTROL, 64, 60);
        push_item(mspd_pkg::ACT_TICK, 0, 0);
        push_item(mspd_pkg::ACT_CONTROL, -128, -32768);
        push_item(mspd_pkg::ACT_CONTROL, 0, 32767);
        push_item(mspd_pkg::ACT_TICK, 0, 0);
        push_item(mspd_pkg::ACT_TICK, 0, 0);
        push_item(mspd_pkg::ACT_CONTROL, 100, 99);
        push_item(mspd_pkg::ACT_CONTROL, 100, 0);
        wait_idle();

        write_all(1023, 1023, 1023, 65535, 1);
        queue_mixed(20);
        wait_idle();

        write_all(0, 0, 0, 0, 0);
        queue_mixed(6);
        wait_idle();

        // Long run of large positive errors pushes the integral to its upper limit.
        write_all($urandom_range(0, 1023), $urandom_range(1, 1023), $urandom_range(0, 1023),
                  65535, $urandom_range(0, 1));
        push_item(mspd_pkg::ACT_CONTROL, 0, 0);
        repeat (260) begin
            push_item(mspd_pkg::ACT_TICK, rnd_cmd(), rnd_meas());
            push_item(mspd_pkg::ACT_CONTROL, ($urandom_range(0, 1) == 0) ? 127 : -128,
                      -32768 + int'($urandom_range(0, 20)));
        end
        wait_idle();

        // A lower duty limit must re-clamp the held duty.
        write_reg(mspd_pkg::CFG_MAX_DUTY, 1000);
        settings_used++;
        push_item(mspd_pkg::ACT_TICK, rnd_cmd(), rnd_meas());
        queue_mixed(10);
        wait_idle();

        if (bridge_duty_q.size() != 0) begin
            mismatches += bridge_duty_q.size();
            $display("%0d expected results never arrived", bridge_duty_q.size());
        end
        $display("Sent %0d items and checked %0d results over %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("(%0d register writes, %0d mismatches).", reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Run did not finish in time");
        $display("== FAIL ==");
        $finish;
    end

endmodule
